@@ rtl/urfc_pkg.sv @@
// ----------------------------------------------------------------------------
// urfc_pkg
// Types, constants and helpers for the UDP/RTP frame header classifier.
// ----------------------------------------------------------------------------
package urfc_pkg;

    typedef enum logic [2:0] {
        PH_LINK = 3'd0,
        PH_IP4  = 3'd1,
        PH_IP6  = 3'd2,
        PH_EXT  = 3'd3,
        PH_UDP  = 3'd4,
        PH_RTP  = 3'd5,
        PH_DONE = 3'd6,
        PH_DROP = 3'd7
    } t_phase;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TRUNC     = 3'd1;
    localparam logic [2:0] ST_BAD_LINK  = 3'd2;
    localparam logic [2:0] ST_BAD_VER   = 3'd3;
    localparam logic [2:0] ST_NOT_UDP   = 3'd4;
    localparam logic [2:0] ST_NO_RANGE  = 3'd5;

    localparam logic [2:0] REG_LINK     = 3'd0;
    localparam logic [2:0] REG_R0_HIGH  = 3'd1;
    localparam logic [2:0] REG_R0_LOW   = 3'd2;
    localparam logic [2:0] REG_R0_CTL   = 3'd3;
    localparam logic [2:0] REG_R1_HIGH  = 3'd4;
    localparam logic [2:0] REG_R1_LOW   = 3'd5;
    localparam logic [2:0] REG_R1_CTL   = 3'd6;

    localparam logic [15:0] ETH_VLAN = 16'h8100;
    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPV6 = 16'h86DD;
    localparam logic [7:0]  NH_HOP   = 8'd0;
    localparam logic [7:0]  NH_ROUTE = 8'd43;
    localparam logic [7:0]  NH_FRAG  = 8'd44;
    localparam logic [7:0]  NH_DOPT  = 8'd60;
    localparam logic [7:0]  NH_UDP   = 8'd17;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       end_of_frame;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic        is_ipv6;
        logic [63:0] dest_high;
        logic [63:0] dest_low;
        logic [15:0] udp_dest_port;
        logic [15:0] rtp_start;
        logic [15:0] rtp_sequence;
        logic [31:0] rtp_time;
        logic [31:0] rtp_source_id;
    } t_out;

    typedef struct packed {
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [9:0]  control;
    } t_range;

    function automatic logic [63:0] top_mask(input logic [7:0] n);
        logic [63:0] m;
        m = '0;
        if (n >= 8'd64) begin
            m = '1;
        end else if (n != 8'd0) begin
            m = ~(64'hFFFF_FFFF_FFFF_FFFF >> n[5:0]);
        end
        return m;
    endfunction

endpackage

@@ rtl/urfc_range.sv @@
// ----------------------------------------------------------------------------
// urfc_range
// Prefix match of a destination address against one configured range.
// ----------------------------------------------------------------------------
module urfc_range
    import urfc_pkg::*;
(
    input  t_range      i_range,
    input  logic [63:0] i_dest_high,
    input  logic [63:0] i_dest_low,
    input  logic        i_v6,
    output logic        o_hit
);
    logic [7:0]  pre;
    logic [63:0] mh;
    logic [63:0] ml;
    logic [7:0]  pre_lo;

    always_comb begin
        pre    = i_range.control[9:2];
        pre_lo = (pre > 8'd64) ? (pre - 8'd64) : 8'd0;
        mh     = top_mask(pre);
        ml     = top_mask(pre_lo);
        o_hit  = 1'b0;
        if (i_range.control[0] && (i_range.control[1] == i_v6)) begin
            if (!i_v6) begin
                o_hit = (pre <= 8'd32) && (((i_dest_high ^ i_range.addr_high) & mh) == '0);
            end else begin
                o_hit = (pre <= 8'd128)
                     && (((i_dest_high ^ i_range.addr_high) & mh) == '0)
                     && (((i_dest_low ^ i_range.addr_low) & ml) == '0);
            end
        end
    end
endmodule

@@ rtl/urfc_parser.sv @@
// ----------------------------------------------------------------------------
// urfc_parser
// Byte-wise header parser; computes the next parse state from one byte.
// ----------------------------------------------------------------------------
module urfc_parser
    import urfc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_take,
    input  t_in          i_in,
    input  logic         i_link_type,
    input  t_range       i_range0,
    input  t_range       i_range1,
    output logic         o_done,
    output t_out         o_result
);
    t_phase       r_phase, n_phase;
    logic [15:0]  r_pos, n_pos;
    logic [16:0]  r_off, n_off;
    logic [15:0]  r_ek, n_ek;
    logic [7:0]   r_hk, n_hk;
    logic [5:0]   r_ihl, n_ihl;
    logic [63:0]  r_dh, n_dh;
    logic [63:0]  r_dl, n_dl;
    logic [15:0]  r_port, n_port;
    logic [63:0]  r_rtp, n_rtp;
    logic [15:0]  r_seq, n_seq;
    logic [2:0]   r_drop, n_drop;

    logic [16:0]  p;
    logic [16:0]  r;
    logic [16:0]  lend;
    logic [7:0]   b;
    logic         v6;
    logic         hit0, hit1;

    assign v6 = (r_ek == ETH_IPV6);

    urfc_range u_range0 (
        .i_range(i_range0), .i_dest_high(r_dh), .i_dest_low(r_dl), .i_v6(v6), .o_hit(hit0)
    );
    urfc_range u_range1 (
        .i_range(i_range1), .i_dest_high(r_dh), .i_dest_low(r_dl), .i_v6(v6), .o_hit(hit1)
    );

    function automatic logic is_ext(input logic [7:0] k);
        return (k == NH_HOP) || (k == NH_ROUTE) || (k == NH_FRAG) || (k == NH_DOPT);
    endfunction

    always_comb begin
        n_phase = r_phase; n_pos = r_pos; n_off = r_off; n_ek = r_ek; n_hk = r_hk;
        n_ihl = r_ihl; n_dh = r_dh; n_dl = r_dl; n_port = r_port; n_rtp = r_rtp;
        n_seq = r_seq; n_drop = r_drop;
        b    = i_in.frame_byte;
        p    = {1'b0, r_pos};
        r    = p - r_off;
        lend = i_link_type ? 17'd16 : ((r_off == 17'd18) ? 17'd18 : 17'd14);

        if (r_pos != 16'hFFFF) begin
            n_pos = r_pos + 16'd1;
            if (r_phase == PH_LINK) begin
                if (p == lend - 17'd2) begin
                    n_ek = {b, 8'h00};
                end else if (p == lend - 17'd1) begin
                    n_ek = {r_ek[15:8], b};
                    if (!i_link_type && lend == 17'd14 && n_ek == ETH_VLAN) begin
                        n_off = 17'd18;
                    end else if (n_ek == ETH_IPV4) begin
                        n_phase = PH_IP4; n_off = lend;
                    end else if (n_ek == ETH_IPV6) begin
                        n_phase = PH_IP6; n_off = lend;
                    end else begin
                        n_drop = ST_BAD_LINK; n_phase = PH_DROP;
                    end
                end
            end else if (r_phase != PH_DONE && r_phase != PH_DROP && p >= r_off) begin
                unique case (r_phase)
                    PH_IP4: begin
                        if (r == 17'd0) begin
                            n_ihl = {b[3:0], 2'b00};
                            if (b[7:4] != 4'd4 || b[3:0] < 4'd5) n_drop = ST_BAD_VER;
                        end else if (r == 17'd9) begin
                            if (r_drop == ST_OK && b != NH_UDP) n_drop = ST_NOT_UDP;
                        end else if (r >= 17'd16 && r <= 17'd19) begin
                            n_dl = {r_dl[55:0], b};
                            if (r == 17'd19) begin
                                if (r_drop != ST_OK) begin
                                    n_phase = PH_DROP;
                                end else begin
                                    n_dh  = {r_dl[23:0], b, 32'h0};
                                    n_dl  = '0;
                                    n_hk  = NH_UDP;
                                    n_off = r_off + {11'd0, r_ihl};
                                    n_phase = PH_UDP;
                                end
                            end
                        end
                    end
                    PH_IP6: begin
                        if (r == 17'd0) begin
                            if (b[7:4] != 4'd6) n_drop = ST_BAD_VER;
                        end else if (r == 17'd6) begin
                            n_hk = b;
                        end else if (r >= 17'd24 && r <= 17'd39) begin
                            n_dh = {r_dh[55:0], r_dl[63:56]};
                            n_dl = {r_dl[55:0], b};
                            if (r == 17'd39) begin
                                if (r_drop != ST_OK) begin
                                    n_phase = PH_DROP;
                                end else begin
                                    n_off = r_off + 17'd40;
                                    if (r_hk == NH_UDP) n_phase = PH_UDP;
                                    else if (is_ext(r_hk)) n_phase = PH_EXT;
                                    else begin
                                        n_drop = ST_NOT_UDP; n_phase = PH_DROP;
                                    end
                                end
                            end
                        end
                    end
                    PH_EXT: begin
                        if (r == 17'd0) n_port = {8'h00, b};
                        if ((r_hk == NH_FRAG && r == 17'd7) ||
                            (r_hk != NH_FRAG && r == 17'd1)) begin
                            n_hk  = r_port[7:0];
                            n_off = (r_hk == NH_FRAG) ? r_off + 17'd8
                                  : r_off + ({9'd0, b} + 17'd1) * 17'd8;
                            if (r_port[7:0] == NH_UDP) n_phase = PH_UDP;
                            else if (is_ext(r_port[7:0])) n_phase = PH_EXT;
                            else begin
                                n_drop = ST_NOT_UDP; n_phase = PH_DROP;
                            end
                        end
                    end
                    PH_UDP: begin
                        if (r == 17'd2 || r == 17'd3) begin
                            n_port = {r_port[7:0], b};
                        end else if (r == 17'd7) begin
                            if (hit0 || hit1) begin
                                n_off = r_off + 17'd8; n_phase = PH_RTP;
                            end else begin
                                n_drop = ST_NO_RANGE; n_phase = PH_DROP;
                            end
                        end
                    end
                    PH_RTP: begin
                        if (r == 17'd2 || r == 17'd3) begin
                            n_seq = {r_seq[7:0], b};
                        end else if (r >= 17'd4 && r <= 17'd11) begin
                            n_rtp = {r_rtp[55:0], b};
                            if (r == 17'd11) n_phase = PH_DONE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        o_result = '0;
        if (n_phase == PH_DONE) begin
            o_result.is_ipv6       = (n_ek == ETH_IPV6);
            o_result.dest_high     = n_dh;
            o_result.dest_low      = n_dl;
            o_result.udp_dest_port = n_port;
            o_result.rtp_start     = n_off[15:0];
            o_result.rtp_sequence  = n_seq;
            o_result.rtp_time      = n_rtp[63:32];
            o_result.rtp_source_id = n_rtp[31:0];
        end else if (n_phase == PH_DROP) begin
            o_result.status = n_drop;
        end else begin
            o_result.status = ST_TRUNC;
        end
        o_done = i_take && i_in.end_of_frame;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_done) begin
            r_phase <= PH_LINK; r_pos <= '0; r_off <= '0; r_ek <= '0; r_hk <= '0;
            r_ihl <= '0; r_dh <= '0; r_dl <= '0; r_port <= '0; r_rtp <= '0;
            r_seq <= '0; r_drop <= ST_OK;
        end else if (i_take) begin
            r_phase <= n_phase; r_pos <= n_pos; r_off <= n_off; r_ek <= n_ek;
            r_hk <= n_hk; r_ihl <= n_ihl; r_dh <= n_dh; r_dl <= n_dl;
            r_port <= n_port; r_rtp <= n_rtp; r_seq <= n_seq; r_drop <= n_drop;
        end
    end
endmodule

@@ rtl/udp_rtp_frame_header_classifier.sv @@
// ----------------------------------------------------------------------------
// udp_rtp_frame_header_classifier
// Latency: the result is valid the cycle after the end-of-frame byte.
// Throughput: one frame byte per cycle while o_ready; result frees on i_ready.
// Reset: synchronous active low; clears parse state, result valid and config.
// ----------------------------------------------------------------------------
module udp_rtp_frame_header_classifier
    import urfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    logic   r_link;
    t_range r_range0, r_range1;
    logic   r_valid;
    t_out   r_data;
    logic   take, done;
    t_out   result;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_valid || i_ready;
    assign take        = i_valid && o_ready;
    assign o_valid     = r_valid;
    assign o_data      = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= 1'b0; r_range0 <= '0; r_range1 <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LINK:    r_link <= i_cfg_data[0];
                REG_R0_HIGH: r_range0.addr_high <= i_cfg_data;
                REG_R0_LOW:  r_range0.addr_low <= i_cfg_data;
                REG_R0_CTL:  r_range0.control <= i_cfg_data[9:0];
                REG_R1_HIGH: r_range1.addr_high <= i_cfg_data;
                REG_R1_LOW:  r_range1.addr_low <= i_cfg_data;
                REG_R1_CTL:  r_range1.control <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    urfc_parser u_parser (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take), .i_in(i_data),
        .i_link_type(r_link), .i_range0(r_range0), .i_range1(r_range1),
        .o_done(done), .o_result(result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (done) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_data <= result;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");
    a_nostall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input taken while result stalled");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.status <= ST_NO_RANGE)
        else $error("bad status code");
endmodule
